FILE: rtl/core/ddo_pkg.sv
// Shared types, constants and tables for the differential drive odometry block.
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF   = 24;
	localparam int POS_FRAC_BITS_DEF  = 16;
	localparam int MUL_W              = 40;
	localparam int TRIG_W             = 34;
	localparam int DYAW_TINY          = 4295;
	localparam int INV_TWO_PI_Q24     = 2670177;
	localparam int CORDIC_GAIN_Q30    = 652032874;
	localparam logic [63:0] MAG_CAP   = 64'h4000_0000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_INC,
		ST_ANG,
		ST_COR_A,
		ST_COR_B,
		ST_DIFF,
		ST_MUL_X,
		ST_DIV_X,
		ST_MUL_Y,
		ST_DIV_Y,
		ST_UPD
	} state_t;

	typedef enum logic [1:0] {
		MSEL_INC,
		MSEL_X,
		MSEL_Y
	} msel_t;

	typedef struct packed {
		logic  load;
		logic  mul_start;
		msel_t mul_sel;
		logic  inc_save;
		logic  cor_start;
		logic  cor_now;
		logic  save_a;
		logic  save_b;
		logic  div_start;
		logic  dx_save;
		logic  dy_save;
		logic  update;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic cor_done;
		logic div_done;
		logic tiny;
		logic out_busy;
	} stat_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module ddo_cordic #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [31:0]                       angle,
	output logic                              done,
	output logic signed [ddo_pkg::TRIG_W-1:0] cos_val,
	output logic signed [ddo_pkg::TRIG_W-1:0] sin_val
);

	localparam int TW = ddo_pkg::TRIG_W;
	localparam int IW = $clog2(CORDIC_STEPS);

	logic                 busy_q;
	logic                 done_q;
	logic [IW-1:0]        cnt_q;
	logic [1:0]           quad_q;
	logic signed [TW-1:0] x_q, y_q, z_q;
	logic signed [TW-1:0] xs, ys, atn;
	logic [1:0]           quad;
	logic [31:0]          folded;

	assign quad   = 2'((angle + 32'h2000_0000) >> 30);
	assign folded = angle - {quad, 30'b0};
	assign xs     = x_q >>> cnt_q;
	assign ys     = y_q >>> cnt_q;
	assign atn    = $signed(TW'(ddo_pkg::atan_bam(5'(cnt_q))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == IW'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= TW'(ddo_pkg::CORDIC_GAIN_Q30);
			y_q    <= '0;
			z_q    <= TW'($signed(folded));
			quad_q <= quad;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (!z_q[TW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

FILE: rtl/core/ddo_datapath.sv
// Odometry datapath: pose state, bit-serial multiplier and divider, CORDIC.
module ddo_datapath #(
	parameter int CORDIC_STEPS       = ddo_pkg::CORDIC_STEPS_DEF,
	parameter int POSITION_FRAC_BITS = ddo_pkg::POS_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ddo_pkg::cmd_t       cmd,
	output ddo_pkg::stat_t      stat,
	input  logic signed [23:0]  linear_velocity,
	input  logic signed [23:0]  yaw_rate,
	input  logic [15:0]         time_step,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [31:0]  pose_x,
	output logic signed [31:0]  pose_y,
	output logic [31:0]         heading
);

	localparam int MW  = ddo_pkg::MUL_W;
	localparam int PW  = 2 * MW + 1;
	localparam int TW  = ddo_pkg::TRIG_W;
	localparam int SH  = 62 - POSITION_FRAC_BITS;
	localparam int DSH = 30 - POSITION_FRAC_BITS;

	// operands and pose
	logic signed [40:0] d_q, p_q, d_prod, p_prod;
	logic [MW-1:0]      d_mag, p_mag;
	logic               tiny;
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [31:0]        head_q, now_q, mid_q;
	logic               out_valid_q;

	assign d_prod = linear_velocity * $signed({1'b0, time_step});
	assign p_prod = yaw_rate * $signed({1'b0, time_step});
	assign d_mag  = d_q[40] ? MW'(-d_q) : MW'(d_q);
	assign p_mag  = p_q[40] ? MW'(-p_q) : MW'(p_q);
	assign tiny   = p_mag < MW'(ddo_pkg::DYAW_TINY);

	// trig results
	logic signed [TW-1:0] ca_q, sa_q, cb_q, sb_q, cor_c, cor_s;
	logic signed [TW:0]   diff_s, diff_c;
	logic                 cor_done;
	logic [31:0]          cor_angle;

	assign diff_s    = (TW+1)'(sb_q) - (TW+1)'(sa_q);
	assign diff_c    = (TW+1)'(ca_q) - (TW+1)'(cb_q);
	assign cor_angle = cmd.cor_now ? now_q : (tiny ? mid_q : head_q);

	ddo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cor_start),
		.angle  (cor_angle),
		.done   (cor_done),
		.cos_val(cor_c),
		.sin_val(cor_s)
	);

	// multiplier operand select
	logic [MW-1:0] op_a, op_b;
	logic          op_neg;

	always_comb begin
		op_a   = d_mag;
		op_b   = '0;
		op_neg = 1'b0;
		case (cmd.mul_sel)
			ddo_pkg::MSEL_INC: begin
				op_a = p_mag;
				op_b = MW'(ddo_pkg::INV_TWO_PI_Q24);
			end
			ddo_pkg::MSEL_X: begin
				if (tiny) begin
					op_b   = ca_q[TW-1] ? MW'(-ca_q) : MW'(ca_q);
					op_neg = d_q[40] ^ ca_q[TW-1];
				end else begin
					op_b   = diff_s[TW] ? MW'(-diff_s) : MW'(diff_s);
					op_neg = d_q[40] ^ diff_s[TW];
				end
			end
			ddo_pkg::MSEL_Y: begin
				if (tiny) begin
					op_b   = sa_q[TW-1] ? MW'(-sa_q) : MW'(sa_q);
					op_neg = d_q[40] ^ sa_q[TW-1];
				end else begin
					op_b   = diff_c[TW] ? MW'(-diff_c) : MW'(diff_c);
					op_neg = d_q[40] ^ diff_c[TW];
				end
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	// shift-add multiplier, one bit a cycle
	logic          mul_busy_q, mul_done_q, mul_neg_q;
	logic [5:0]    mul_cnt_q;
	logic [MW-1:0] mul_a_q;
	logic [PW-1:0] mul_p_q;
	logic [MW:0]   mul_upper;
	logic [2*MW-1:0] mul_prod;

	assign mul_upper = mul_p_q[0] ? (mul_p_q[PW-1:MW] + {1'b0, mul_a_q}) : mul_p_q[PW-1:MW];
	assign mul_prod  = mul_p_q[2*MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
		end else begin
			mul_done_q <= 1'b0;
			if (cmd.mul_start) begin
				mul_busy_q <= 1'b1;
			end else if (mul_busy_q && mul_cnt_q == 6'(MW - 1)) begin
				mul_busy_q <= 1'b0;
				mul_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q   <= op_a;
			mul_p_q   <= {{(MW+1){1'b0}}, op_b};
			mul_neg_q <= op_neg;
			mul_cnt_q <= '0;
		end else if (mul_busy_q) begin
			mul_p_q   <= {1'b0, mul_upper, mul_p_q[MW-1:1]};
			mul_cnt_q <= mul_cnt_q + 1'b1;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic [63:0] den, div_d_q, div_rem_q, div_n_q, div_q_q;
	logic [PW-1:0] numer;
	logic        div_sat, div_busy_q, div_done_q, div_sat_q;
	logic [5:0]  div_cnt_q;
	logic [64:0] rem_sh;
	logic        rem_ge;

	assign den     = 64'(p_mag) << DSH;
	assign numer   = {1'b0, mul_prod} + PW'(den >> 1);
	assign div_sat = (den == '0) || (64'(numer[PW-1:64]) >= den);
	assign rem_sh  = {div_rem_q, div_n_q[63]};
	assign rem_ge  = rem_sh >= {1'b0, div_d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= !div_sat;
				div_done_q <= div_sat;
			end else if (div_busy_q && div_cnt_q == 6'd63) begin
				div_busy_q <= 1'b0;
				div_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_d_q   <= den;
			div_rem_q <= 64'(numer[PW-1:64]);
			div_n_q   <= numer[63:0];
			div_q_q   <= '0;
			div_sat_q <= div_sat;
			div_cnt_q <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= rem_ge ? 64'(rem_sh - {1'b0, div_d_q}) : rem_sh[63:0];
			div_n_q   <= {div_n_q[62:0], 1'b0};
			div_q_q   <= {div_q_q[62:0], rem_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// heading increment
	logic [PW-1:0] inc_sum;
	logic [32:0]   inc_mag;

	assign inc_sum = {1'b0, mul_prod} + PW'(24'h80_0000);
	assign inc_mag = inc_sum[24 +: 33];

	// position deltas
	logic [PW-1:0]      st_sum;
	logic [63:0]        dmag_raw, dmag;
	logic               dneg;
	logic signed [63:0] delta, dx_q, dy_q;
	logic signed [64:0] sum_x, sum_y;

	assign st_sum   = {1'b0, mul_prod} + (PW'(1) << (SH - 1));
	assign dmag_raw = tiny ? 64'(st_sum >> SH) : (div_sat_q ? '1 : div_q_q);
	assign dmag     = (dmag_raw > ddo_pkg::MAG_CAP) ? ddo_pkg::MAG_CAP : dmag_raw;
	assign dneg     = tiny ? mul_neg_q : (mul_neg_q ^ p_q[40]);
	assign delta    = dneg ? -$signed(dmag) : $signed(dmag);
	assign sum_x    = 65'(pos_x_q) + 65'(dx_q);
	assign sum_y    = 65'(pos_y_q) + 65'(dy_q);

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -65'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = 32'(v);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q <= d_prod;
			p_q <= p_prod;
		end
		if (cmd.inc_save) begin
			now_q <= p_q[40] ? head_q - inc_mag[31:0] : head_q + inc_mag[31:0];
			mid_q <= p_q[40] ? head_q - inc_mag[32:1] : head_q + inc_mag[32:1];
		end
		if (cmd.save_a) begin
			ca_q <= cor_c;
			sa_q <= cor_s;
		end
		if (cmd.save_b) begin
			cb_q <= cor_c;
			sb_q <= cor_s;
		end
		if (cmd.dx_save)
			dx_q <= delta;
		if (cmd.dy_save)
			dy_q <= delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				pos_x_q     <= sat32(sum_x);
				pos_y_q     <= sat32(sum_y);
				head_q      <= now_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.mul_done = mul_done_q;
	assign stat.cor_done = cor_done;
	assign stat.div_done = div_done_q;
	assign stat.tiny     = tiny;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign pose_x    = pos_x_q;
	assign pose_y    = pos_y_q;
	assign heading   = head_q;

	a_mul_div_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy_q && div_busy_q))
		else $error("multiplier and divider busy together");

	a_update_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !(out_valid_q && !out_ready))
		else $error("pose update while result word still pending");

	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !mul_busy_q && !div_busy_q)
		else $error("multiplier started while busy");

endmodule

FILE: rtl/core/ddo_ctrl.sv
// Sequencing state machine for the odometry datapath.
module ddo_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ddo_pkg::stat_t stat,
	output ddo_pkg::cmd_t  cmd
);

	ddo_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.mul_sel = ddo_pkg::MSEL_INC;
		in_ready = 1'b0;
		case (state_q)
			ddo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ddo_pkg::ST_PREP;
				end
			end
			ddo_pkg::ST_PREP: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = ddo_pkg::MSEL_INC;
				state_d       = ddo_pkg::ST_INC;
			end
			ddo_pkg::ST_INC: begin
				if (stat.mul_done) begin
					cmd.inc_save = 1'b1;
					state_d      = ddo_pkg::ST_ANG;
				end
			end
			ddo_pkg::ST_ANG: begin
				cmd.cor_start = 1'b1;
				state_d       = ddo_pkg::ST_COR_A;
			end
			ddo_pkg::ST_COR_A: begin
				if (stat.cor_done) begin
					cmd.save_a = 1'b1;
					if (stat.tiny) begin
						state_d = ddo_pkg::ST_DIFF;
					end else begin
						cmd.cor_start = 1'b1;
						cmd.cor_now   = 1'b1;
						state_d       = ddo_pkg::ST_COR_B;
					end
				end
			end
			ddo_pkg::ST_COR_B: begin
				if (stat.cor_done) begin
					cmd.save_b = 1'b1;
					state_d    = ddo_pkg::ST_DIFF;
				end
			end
			ddo_pkg::ST_DIFF: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = ddo_pkg::MSEL_X;
				state_d       = ddo_pkg::ST_MUL_X;
			end
			ddo_pkg::ST_MUL_X: begin
				cmd.mul_sel = ddo_pkg::MSEL_X;
				if (stat.mul_done) begin
					if (stat.tiny) begin
						cmd.dx_save   = 1'b1;
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = ddo_pkg::MSEL_Y;
						state_d       = ddo_pkg::ST_MUL_Y;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = ddo_pkg::ST_DIV_X;
					end
				end
			end
			ddo_pkg::ST_DIV_X: begin
				if (stat.div_done) begin
					cmd.dx_save   = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = ddo_pkg::MSEL_Y;
					state_d       = ddo_pkg::ST_MUL_Y;
				end
			end
			ddo_pkg::ST_MUL_Y: begin
				cmd.mul_sel = ddo_pkg::MSEL_Y;
				if (stat.mul_done) begin
					if (stat.tiny) begin
						cmd.dy_save = 1'b1;
						state_d     = ddo_pkg::ST_UPD;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = ddo_pkg::ST_DIV_Y;
					end
				end
			end
			ddo_pkg::ST_DIV_Y: begin
				if (stat.div_done) begin
					cmd.dy_save = 1'b1;
					state_d     = ddo_pkg::ST_UPD;
				end
			end
			ddo_pkg::ST_UPD: begin
				if (!stat.out_busy) begin
					cmd.update = 1'b1;
					state_d    = ddo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ddo_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/differential_drive_odometry.sv
// Top level of the differential drive dead-reckoning pose integrator.
//
//  channel | direction | handshake          | word
//  in      | sink      | in_valid/in_ready   | linear_velocity, yaw_rate, time_step
//  out     | source    | out_valid/out_ready | pose_x, pose_y, heading
//
// One word at a time. Straight steps use the bit-serial multiplier and one pass
// of the iterative CORDIC; arc steps use two CORDIC passes and the restoring
// divider as well.
// Reset clears the pose and heading to zero. A new word is taken while the
// previous result waits; the pose update holds until that result is taken.
module differential_drive_odometry #(
	parameter int CORDIC_STEPS       = ddo_pkg::CORDIC_STEPS_DEF,
	parameter int POSITION_FRAC_BITS = ddo_pkg::POS_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] linear_velocity,
	input  logic signed [23:0] yaw_rate,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic [31:0]        heading
);

	ddo_pkg::cmd_t  cmd;
	ddo_pkg::stat_t stat;

	ddo_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ddo_datapath #(
		.CORDIC_STEPS      (CORDIC_STEPS),
		.POSITION_FRAC_BITS(POSITION_FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.linear_velocity(linear_velocity),
		.yaw_rate       (yaw_rate),
		.time_step      (time_step),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.pose_x         (pose_x),
		.pose_y         (pose_y),
		.heading        (heading)
	);

endmodule

FILE: tb/sv/tb_differential_drive_odometry.sv
// Testbench for the differential drive odometry block: random and directed words against a predictor.
`timescale 1ns / 100ps

class pose_scoreboard;
	logic signed [31:0] px, py;
	logic [31:0] hd;
	logic [95:0] pending[$];
	int errors;

	function new();
		px = 0; py = 0; hd = 0; errors = 0;
	endfunction

	static function logic [31:0] atan_step(int i);
		logic [31:0] t[32] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
			32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
			32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
			32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
			32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003,
			32'h00000001, 32'h00000001, 32'h00000000};
		return t[i];
	endfunction

	static function void sincos(logic [31:0] a, output longint c, output longint s);
		logic [1:0] q;
		logic [31:0] u;
		longint z, x, y, xs, ys;
		q = 2'((a + 32'h20000000) >> 30);
		u = a - ({30'd0, q} << 30);
		z = longint'($signed(u));
		x = ddo_pkg::CORDIC_GAIN_Q30;
		y = 0;
		for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atan_step(i));
			end else begin
				x += ys; y -= xs; z += longint'(atan_step(i));
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	static function logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	static function longint apply_sign(logic [63:0] m, bit neg);
		if (m > ddo_pkg::MAG_CAP) m = ddo_pkg::MAG_CAP;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	static function longint straight_step(longint d, longint t);
		int sh;
		logic [127:0] p;
		sh = 62 - ddo_pkg::POS_FRAC_BITS_DEF;
		p = {64'd0, mag(d)} * {64'd0, mag(t)};
		p = (p + (128'd1 << (sh - 1))) >> sh;
		return apply_sign(p[127:64] != 0 ? '1 : p[63:0], (d < 0) != (t < 0));
	endfunction

	static function longint arc_step(longint d, longint diff, longint p);
		logic [63:0] den, q;
		logic [127:0] n, qw;
		den = mag(p) << (30 - ddo_pkg::POS_FRAC_BITS_DEF);
		n = {64'd0, mag(d)} * {64'd0, mag(diff)} + {65'd0, den[63:1]};
		qw = n / {64'd0, den};
		q = qw[127:64] != 0 ? '1 : qw[63:0];
		return apply_sign(q, ((d < 0) != (diff < 0)) != (p < 0));
	endfunction

	static function logic signed [31:0] clamp(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return 32'(v);
	endfunction

	function void note_word(logic signed [23:0] v, logic signed [23:0] w, logic [15:0] dt);
		longint d, p, inc, dx, dy, c0, s0, c1, s1;
		logic [63:0] im;
		logic [31:0] nh;
		d = longint'(v) * longint'({1'b0, dt});
		p = longint'(w) * longint'({1'b0, dt});
		im = (mag(p) * 64'(ddo_pkg::INV_TWO_PI_Q24) + (64'd1 << 23)) >> 24;
		inc = p < 0 ? -longint'(im) : longint'(im);
		nh = hd + 32'(inc);
		if (p > -ddo_pkg::DYAW_TINY && p < ddo_pkg::DYAW_TINY) begin
			sincos(hd + 32'(inc / 2), c0, s0);
			dx = straight_step(d, c0);
			dy = straight_step(d, s0);
		end else begin
			sincos(hd, c0, s0);
			sincos(nh, c1, s1);
			dx = arc_step(d, s1 - s0, p);
			dy = arc_step(d, c0 - c1, p);
		end
		px = clamp(longint'(px) + dx);
		py = clamp(longint'(py) + dy);
		hd = nh;
		pending.push_back({px, py, hd});
	endfunction

	function void check_pose(logic [31:0] x, logic [31:0] y, logic [31:0] h);
		logic [95:0] e;
		if (pending.size() == 0) begin
			$error("pose word with none expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (x !== e[95:64]) begin
			$error("pose_x exp %0d got %0d", $signed(e[95:64]), $signed(x)); errors++;
		end
		if (y !== e[63:32]) begin
			$error("pose_y exp %0d got %0d", $signed(e[63:32]), $signed(y)); errors++;
		end
		if (h !== e[31:0]) begin
			$error("heading exp %0h got %0h", e[31:0], h); errors++;
		end
	endfunction
endclass

module tb_differential_drive_odometry;
	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [23:0] linear_velocity = 0, yaw_rate = 0;
	logic [15:0] time_step = 0;
	logic signed [31:0] pose_x, pose_y;
	logic [31:0] heading;
	pose_scoreboard sb = new();
	bit sending_done = 0, long_hold = 0;
	int idle_cycles = 0;

	always #1 clk = ~clk;

	differential_drive_odometry DUT (.*);

	task automatic send_word(logic [23:0] v, logic [23:0] w, logic [15:0] dt);
		int gap;
		gap = $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; linear_velocity <= v; yaw_rate <= w; time_step <= dt;
		do @(posedge clk); while (!in_ready);
		sb.note_word(v, w, dt);
	endtask

	task automatic send_random();
		logic [23:0] v, w;
		logic [15:0] dt;
		case ($urandom_range(0, 5))
			0: begin v = 24'($urandom); w = 24'($urandom); dt = 16'($urandom); end
			1: begin v = 24'($urandom); w = 24'($urandom_range(0, 2) - 1);
				dt = 16'($urandom); end
			2: begin v = 24'($urandom_range(0, 200000) - 100000);
				w = 24'($urandom_range(0, 200000) - 100000);
				dt = 16'($urandom_range(0, 2000)); end
			3: begin v = 24'($urandom); w = 24'($urandom_range(0, 8) - 4);
				dt = 16'($urandom_range(0, 1100)); end
			default: begin v = 24'($urandom_range(0, 4000000) - 2000000);
				w = 24'($urandom_range(0, 400000) - 200000);
				dt = 16'($urandom_range(0, 1000)); end
		endcase
		send_word(v, w, dt);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_word(24'h7FFFFF, 24'h000000, 16'hFFFF);
		send_word(24'h800000, 24'h000000, 16'hFFFF);
		send_word(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
		send_word(24'h800000, 24'h800000, 16'hFFFF);
		send_word(24'h7FFFFF, 24'h800000, 16'hFFFF);
		send_word(24'h000000, 24'h7FFFFF, 16'hFFFF);
		send_word(24'h7FFFFF, 24'h7FFFFF, 16'h0000);
		send_word(24'h010000, 24'h000001, 16'h1000);
		send_word(24'h010000, 24'hFFFFFF, 16'h1000);
		send_word(24'h010000, 24'h000001, 16'h10C7);
		send_word(24'h010000, 24'h000001, 16'h10C6);
		send_word(24'h010000, 24'hFFFFFF, 16'h10C7);
		send_word(24'h123456, 24'h032440, 16'h8000);
		send_word(24'hFEDCBA, 24'hFCDBC0, 16'h8000);
		for (int i = 0; i < 20; i++) send_word(24'h7FFFFF, 24'h000000, 16'hFFFF);
		for (int i = 0; i < 20; i++) send_word(24'h800000, 24'h000000, 16'hFFFF);
		long_hold = 1;
		for (int i = 0; i < 1300; i++) send_random();
		in_valid <= 0;
		sending_done = 1;
	end

	always @(posedge clk) begin
		static int wait_left = 0;
		static int hold_left = 0;
		if (long_hold && hold_left == 0 && !sb.errors[31]) begin
			if (out_valid && out_ready) sb.check_pose(pose_x, pose_y, heading);
			hold_left = 3000;
			long_hold = 0;
			out_ready <= 0;
		end else if (hold_left > 1) begin
			hold_left--;
		end else if (out_valid && out_ready) begin
			sb.check_pose(pose_x, pose_y, heading);
			wait_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
			out_ready <= (wait_left == 0);
		end else if (wait_left > 0) begin
			wait_left--;
			out_ready <= (wait_left == 0);
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 12000) begin
			$display("tb_differential_drive_odometry: FAIL");
			$finish;
		end
	end

	initial begin
		wait (sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0) $display("tb_differential_drive_odometry: PASS");
		else $display("tb_differential_drive_odometry: FAIL");
		$finish;
	end
endmodule
